// ===== sv/scc_pkg.sv =====
// Shared types and constants for the strongly connected components block.
package scc_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_EDGES_DEF = 256;
    localparam int MAX_COMP      = 32;
    localparam int COMP_AW       = 5;
    localparam int COMP_CW       = 6;
    localparam int NODE_ID_W     = 6;
    localparam int COUNT_W       = 7;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_LOW_CHK,
        S_POP_RD,
        S_POP_CHK,
        S_PARENT,
        S_RESTORE,
        S_EM_RD,
        S_EM_CHK,
        S_EM_WAIT,
        S_DONE
    } state_t;

endpackage

// ===== sv/strongly_connected_components_top.sv =====
// Top level of the strongly connected components search engine.
//
//  Channel  Direction  Ports                              Contents
//  s_       in         s_tvalid s_tready s_tdata s_tuser  edge load or run command
//  m_       out        m_tvalid m_tready m_tdata m_tuser  one component per transaction
//                      m_tlast
//
// Edge loads are taken while idle; the block is ready again on the next cycle.
// A run steps once through every root id, walks the edge store edge by edge (with an
// extra low-link check when the edge leads back onto the stack), leaves or pops nodes,
// then scans the component store once per candidate size (up to MAX_NODES-1 sizes,
// reading each stored component), so its length depends on the graph. Reset is
// synchronous and active low; no memory needs clearing.
// A stalled output transaction holds the engine until it is taken.
module strongly_connected_components_top #(
    parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] src_node, [11:6] dst_node, [15:12] zero
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] member_mask, [70:64] member_count, [71] zero
    output logic [1:0]  m_tuser,   // [0] none_found, [1] edges_dropped
    output logic        m_tlast    // last_component
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int OW  = $clog2(MAX_NODES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int FW  = NW + ECW + OW + OW;
    localparam int CW  = MAX_NODES + OW;
    localparam logic [MAX_NODES-1:0] ONE = MAX_NODES'(1);

    scc_pkg::state_t state_reg, state_next;

    // Control registers.
    logic [ECW-1:0]             edge_cnt_reg, edge_cnt_next;
    logic                       ovf_reg, ovf_next;
    logic [MAX_NODES-1:0]       present_reg, present_next;
    logic [MAX_NODES-1:0]       visited_reg, visited_next;
    logic [MAX_NODES-1:0]       onstk_reg, onstk_next;
    logic [OW-1:0]              sp_reg, sp_next;
    logic [OW-1:0]              depth_reg, depth_next;
    logic [OW-1:0]              oc_reg, oc_next;
    logic [scc_pkg::COMP_CW-1:0] comp_cnt_reg, comp_cnt_next;
    logic [OW-1:0]              root_reg, root_next;
    logic [OW-1:0]              size_reg, size_next;
    logic [scc_pkg::COMP_AW-1:0] idx_reg, idx_next;
    logic [scc_pkg::COMP_CW-1:0] emitted_reg, emitted_next;
    logic                       out_valid_reg, out_valid_next;

    // Working registers of the top call frame and the pop sweep.
    logic [NW-1:0]              cur_v_reg, cur_v_next;
    logic [ECW-1:0]             cur_e_reg, cur_e_next;
    logic [OW-1:0]              cur_ord_reg, cur_ord_next;
    logic [OW-1:0]              cur_low_reg, cur_low_next;
    logic [MAX_NODES-1:0]       pmask_reg, pmask_next;
    logic [OW-1:0]              pcnt_reg, pcnt_next;

    // Output payload.
    logic [MAX_NODES-1:0]       out_mask_reg, out_mask_next;
    logic [OW-1:0]              out_cnt_reg, out_cnt_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_none_reg, out_none_next;
    logic                       out_drop_reg, out_drop_next;

    // Memory ports.
    logic                edge_we;
    logic [EAW-1:0]      edge_waddr, edge_raddr;
    logic [2*NW-1:0]     edge_wdata, edge_rdata;
    logic                info_we;
    logic [NW-1:0]       info_waddr, info_raddr;
    logic [OW-1:0]       info_wdata, info_rdata;
    logic                stk_we;
    logic [NW-1:0]       stk_waddr, stk_raddr;
    logic [NW-1:0]       stk_wdata, stk_rdata;
    logic                frm_we;
    logic [NW-1:0]       frm_waddr, frm_raddr;
    logic [FW-1:0]       frm_wdata, frm_rdata;
    logic                comp_we;
    logic [scc_pkg::COMP_AW-1:0] comp_waddr, comp_raddr;
    logic [CW-1:0]       comp_wdata, comp_rdata;

    // Input decode.
    logic [scc_pkg::NODE_ID_W-1:0] in_src, in_dst;
    logic                          in_op;
    logic                          s_fire;
    assign in_src = s_tdata[5:0];
    assign in_dst = s_tdata[11:6];
    assign in_op  = s_tuser[0];
    assign s_fire = s_tvalid && s_tready;
    assign s_tready = (state_reg == scc_pkg::S_IDLE);

    // Decoded fields of the memory read data.
    logic [NW-1:0]  e_src, e_dst;
    logic [NW-1:0]  f_v;
    logic [ECW-1:0] f_e;
    logic [OW-1:0]  f_ord, f_low;
    logic [OW-1:0]  c_cnt;
    assign e_src = edge_rdata[2*NW-1:NW];
    assign e_dst = edge_rdata[NW-1:0];
    assign {f_v, f_e, f_ord, f_low} = frm_rdata;
    assign c_cnt = comp_rdata[MAX_NODES +: OW];

    logic [OW-1:0] sp_m1, depth_m1, depth_m2;
    logic [OW-1:0] pcnt_inc;
    logic          edge_left, root_new, pop_hit, last_idx, em_match;
    logic [scc_pkg::COMP_CW-1:0] emitted_inc;
    assign sp_m1       = sp_reg - OW'(1);
    assign depth_m1    = depth_reg - OW'(1);
    assign depth_m2    = depth_reg - OW'(2);
    assign pcnt_inc    = pcnt_reg + OW'(1);
    assign edge_left   = cur_e_reg < edge_cnt_reg;
    assign root_new    = present_reg[root_reg[NW-1:0]] && !visited_reg[root_reg[NW-1:0]];
    assign pop_hit     = stk_rdata == cur_v_reg;
    assign last_idx    = (scc_pkg::COMP_CW'(idx_reg) + scc_pkg::COMP_CW'(1)) == comp_cnt_reg;
    assign em_match    = c_cnt == size_reg;
    assign emitted_inc = emitted_reg + scc_pkg::COMP_CW'(1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            scc_pkg::S_IDLE: begin
                if (s_fire && in_op == scc_pkg::OP_RUN) state_next = scc_pkg::S_ROOT;
            end
            scc_pkg::S_ROOT: begin
                if (root_reg == OW'(MAX_NODES)) begin
                    state_next = (comp_cnt_reg == '0) ? scc_pkg::S_EM_WAIT : scc_pkg::S_EM_RD;
                end else if (root_new) begin
                    state_next = scc_pkg::S_EDGE_RD;
                end
            end
            scc_pkg::S_EDGE_RD: begin
                if (edge_left) state_next = scc_pkg::S_EDGE_CHK;
                else if (cur_low_reg == cur_ord_reg) state_next = scc_pkg::S_POP_RD;
                else state_next = scc_pkg::S_PARENT;
            end
            scc_pkg::S_EDGE_CHK: begin
                if (e_src == cur_v_reg && visited_reg[e_dst] && onstk_reg[e_dst]) begin
                    state_next = scc_pkg::S_LOW_CHK;
                end else begin
                    state_next = scc_pkg::S_EDGE_RD;
                end
            end
            scc_pkg::S_LOW_CHK: state_next = scc_pkg::S_EDGE_RD;
            scc_pkg::S_POP_RD:  state_next = scc_pkg::S_POP_CHK;
            scc_pkg::S_POP_CHK: state_next = pop_hit ? scc_pkg::S_PARENT : scc_pkg::S_POP_RD;
            scc_pkg::S_PARENT: begin
                state_next = (depth_reg == OW'(1)) ? scc_pkg::S_ROOT : scc_pkg::S_RESTORE;
            end
            scc_pkg::S_RESTORE: state_next = scc_pkg::S_EDGE_RD;
            scc_pkg::S_EM_RD:   state_next = scc_pkg::S_EM_CHK;
            scc_pkg::S_EM_CHK:  state_next = em_match ? scc_pkg::S_EM_WAIT : scc_pkg::S_EM_RD;
            scc_pkg::S_EM_WAIT: begin
                if (m_tready) state_next = out_last_reg ? scc_pkg::S_DONE : scc_pkg::S_EM_RD;
            end
            scc_pkg::S_DONE:    state_next = scc_pkg::S_IDLE;
            default:            state_next = scc_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        logic          do_enter;
        logic [NW-1:0] enter_node;
        logic          advance;

        edge_cnt_next = edge_cnt_reg;
        ovf_next      = ovf_reg;
        present_next  = present_reg;
        visited_next  = visited_reg;
        onstk_next    = onstk_reg;
        sp_next       = sp_reg;
        depth_next    = depth_reg;
        oc_next       = oc_reg;
        comp_cnt_next = comp_cnt_reg;
        root_next     = root_reg;
        size_next     = size_reg;
        idx_next      = idx_reg;
        emitted_next  = emitted_reg;
        out_valid_next = out_valid_reg;
        cur_v_next    = cur_v_reg;
        cur_e_next    = cur_e_reg;
        cur_ord_next  = cur_ord_reg;
        cur_low_next  = cur_low_reg;
        pmask_next    = pmask_reg;
        pcnt_next     = pcnt_reg;
        out_mask_next = out_mask_reg;
        out_cnt_next  = out_cnt_reg;
        out_last_next = out_last_reg;
        out_none_next = out_none_reg;
        out_drop_next = out_drop_reg;

        edge_we    = 1'b0;
        edge_waddr = edge_cnt_reg[EAW-1:0];
        edge_wdata = {in_src[NW-1:0], in_dst[NW-1:0]};
        edge_raddr = cur_e_reg[EAW-1:0];
        info_we    = 1'b0;
        info_waddr = cur_v_reg;
        info_wdata = oc_reg;
        info_raddr = e_dst;
        stk_we     = 1'b0;
        stk_waddr  = sp_reg[NW-1:0];
        stk_wdata  = cur_v_reg;
        stk_raddr  = sp_m1[NW-1:0];
        frm_we     = 1'b0;
        frm_waddr  = depth_m1[NW-1:0];
        frm_wdata  = {cur_v_reg, cur_e_reg + ECW'(1), cur_ord_reg, cur_low_reg};
        frm_raddr  = depth_m2[NW-1:0];
        comp_we    = 1'b0;
        comp_waddr = comp_cnt_reg[scc_pkg::COMP_AW-1:0];
        comp_wdata = {pcnt_inc, pmask_reg | (ONE << stk_rdata)};
        comp_raddr = idx_reg;

        do_enter   = 1'b0;
        enter_node = root_reg[NW-1:0];
        advance    = 1'b0;

        unique case (state_reg)
            scc_pkg::S_IDLE: begin
                if (s_fire && in_op == scc_pkg::OP_LOAD &&
                    {1'b0, in_src} < 7'(MAX_NODES) && {1'b0, in_dst} < 7'(MAX_NODES)) begin
                    if (in_src == in_dst) begin
                        present_next = present_reg | (ONE << in_src[NW-1:0]);
                    end else if (edge_cnt_reg >= ECW'(MAX_EDGES)) begin
                        ovf_next = 1'b1;
                    end else begin
                        present_next = present_reg | (ONE << in_src[NW-1:0])
                                                   | (ONE << in_dst[NW-1:0]);
                        edge_we       = 1'b1;
                        edge_cnt_next = edge_cnt_reg + ECW'(1);
                    end
                end
                root_next = '0;
            end
            scc_pkg::S_ROOT: begin
                if (root_reg == OW'(MAX_NODES)) begin
                    size_next    = OW'(MAX_NODES);
                    idx_next     = '0;
                    emitted_next = '0;
                    if (comp_cnt_reg == '0) begin
                        // No component of two or more nodes: one none-found transaction.
                        out_valid_next = 1'b1;
                        out_mask_next  = '0;
                        out_cnt_next   = '0;
                        out_last_next  = 1'b1;
                        out_none_next  = 1'b1;
                        out_drop_next  = ovf_reg;
                    end
                end else begin
                    root_next = root_reg + OW'(1);
                    if (root_new) do_enter = 1'b1;
                end
            end
            scc_pkg::S_EDGE_RD: begin
                if (!edge_left && cur_low_reg == cur_ord_reg) begin
                    pmask_next = '0;
                    pcnt_next  = '0;
                end
            end
            scc_pkg::S_EDGE_CHK: begin
                cur_e_next = cur_e_reg + ECW'(1);
                if (e_src == cur_v_reg && !visited_reg[e_dst]) begin
                    // Descend: save the parent frame, then enter the child.
                    frm_we     = 1'b1;
                    do_enter   = 1'b1;
                    enter_node = e_dst;
                end
            end
            scc_pkg::S_LOW_CHK: begin
                if (info_rdata < cur_low_reg) cur_low_next = info_rdata;
            end
            scc_pkg::S_POP_RD: begin
            end
            scc_pkg::S_POP_CHK: begin
                onstk_next = onstk_reg & ~(ONE << stk_rdata);
                pmask_next = pmask_reg | (ONE << stk_rdata);
                pcnt_next  = pcnt_inc;
                sp_next    = sp_m1;
                if (pop_hit && pcnt_inc >= OW'(2) &&
                    comp_cnt_reg < scc_pkg::COMP_CW'(scc_pkg::MAX_COMP)) begin
                    comp_we       = 1'b1;
                    comp_cnt_next = comp_cnt_reg + scc_pkg::COMP_CW'(1);
                end
            end
            scc_pkg::S_PARENT: begin
                depth_next = depth_m1;
            end
            scc_pkg::S_RESTORE: begin
                cur_v_next   = f_v;
                cur_e_next   = f_e;
                cur_ord_next = f_ord;
                cur_low_next = (cur_low_reg < f_low) ? cur_low_reg : f_low;
            end
            scc_pkg::S_EM_RD: begin
            end
            scc_pkg::S_EM_CHK: begin
                if (em_match) begin
                    out_valid_next = 1'b1;
                    out_mask_next  = comp_rdata[MAX_NODES-1:0];
                    out_cnt_next   = c_cnt;
                    out_last_next  = emitted_inc == comp_cnt_reg;
                    out_none_next  = 1'b0;
                    out_drop_next  = ovf_reg;
                    emitted_next   = emitted_inc;
                end else begin
                    advance = 1'b1;
                end
            end
            scc_pkg::S_EM_WAIT: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    advance        = !out_last_reg;
                end
            end
            scc_pkg::S_DONE: begin
                edge_cnt_next = '0;
                ovf_next      = 1'b0;
                present_next  = '0;
                visited_next  = '0;
                onstk_next    = '0;
                sp_next       = '0;
                depth_next    = '0;
                oc_next       = '0;
                comp_cnt_next = '0;
            end
            default: begin
            end
        endcase

        if (advance) begin
            if (last_idx) begin
                idx_next  = '0;
                size_next = size_reg - OW'(1);
            end else begin
                idx_next = idx_reg + scc_pkg::COMP_AW'(1);
            end
        end

        if (do_enter) begin
            visited_next = visited_reg | (ONE << enter_node);
            onstk_next   = onstk_reg | (ONE << enter_node);
            info_we      = 1'b1;
            info_waddr   = enter_node;
            stk_we       = 1'b1;
            stk_wdata    = enter_node;
            sp_next      = sp_reg + OW'(1);
            depth_next   = depth_reg + OW'(1);
            oc_next      = oc_reg + OW'(1);
            cur_v_next   = enter_node;
            cur_e_next   = '0;
            cur_ord_next = oc_reg;
            cur_low_next = oc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= scc_pkg::S_IDLE;
            edge_cnt_reg  <= '0;
            ovf_reg       <= 1'b0;
            present_reg   <= '0;
            visited_reg   <= '0;
            onstk_reg     <= '0;
            sp_reg        <= '0;
            depth_reg     <= '0;
            oc_reg        <= '0;
            comp_cnt_reg  <= '0;
            root_reg      <= '0;
            size_reg      <= '0;
            idx_reg       <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            edge_cnt_reg  <= edge_cnt_next;
            ovf_reg       <= ovf_next;
            present_reg   <= present_next;
            visited_reg   <= visited_next;
            onstk_reg     <= onstk_next;
            sp_reg        <= sp_next;
            depth_reg     <= depth_next;
            oc_reg        <= oc_next;
            comp_cnt_reg  <= comp_cnt_next;
            root_reg      <= root_next;
            size_reg      <= size_next;
            idx_reg       <= idx_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_v_reg    <= cur_v_next;
        cur_e_reg    <= cur_e_next;
        cur_ord_reg  <= cur_ord_next;
        cur_low_reg  <= cur_low_next;
        pmask_reg    <= pmask_next;
        pcnt_reg     <= pcnt_next;
        out_mask_reg <= out_mask_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
        out_none_reg <= out_none_next;
        out_drop_reg <= out_drop_next;
    end

    // Edge store, in load order.
    scc_ram #(.WIDTH(2*NW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_rdata)
    );

    // Visit order of each node, written when the node is entered.
    scc_ram #(.WIDTH(OW), .DEPTH(MAX_NODES)) u_info_ram (
        .aclk(aclk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
        .raddr(info_raddr), .rdata(info_rdata)
    );

    // Tarjan node stack.
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack_ram (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // Suspended call frames; the active frame lives in the cur_* registers.
    scc_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) u_frame_ram (
        .aclk(aclk), .we(frm_we), .waddr(frm_waddr), .wdata(frm_wdata),
        .raddr(frm_raddr), .rdata(frm_rdata)
    );

    // Completed components of two or more nodes (up to MAX_COMP), with their member counts, in completion order.
    scc_ram #(.WIDTH(CW), .DEPTH(scc_pkg::MAX_COMP)) u_comp_ram (
        .aclk(aclk), .we(comp_we), .waddr(comp_waddr), .wdata(comp_wdata),
        .raddr(comp_raddr), .rdata(comp_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, 7'(out_cnt_reg), 64'(out_mask_reg)};
    assign m_tuser  = {out_drop_reg, out_none_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== sv/scc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
